### rtl/core/dbp_pkg.sv
// Package for the div/mod bounds propagator: widths, item types and register codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package dbp_pkg;

    // Width of every bound value.
    localparam int VW = 32;
    // Width of the double-width products and sums.
    localparam int DW = 2 * VW;
    // Width of the divisor register.
    localparam int CW = 31;
    // One quotient bit per divider stage.
    localparam int NSTG = VW;
    // APB address width and the divisor register address.
    localparam int AW = 3;
    localparam logic [AW-1:0] ADDR_DIVISOR = 3'd0;
    localparam logic [CW-1:0] DIVISOR_RESET = 31'd1;
    // Queue depth between front and back.
    localparam int QD = 4;
    localparam int QAW = $clog2(QD);

    typedef struct packed {
        logic signed [VW-1:0] x_lower;
        logic signed [VW-1:0] x_upper;
        logic signed [VW-1:0] q_lower;
        logic signed [VW-1:0] q_upper;
        logic signed [VW-1:0] r_lower;
        logic signed [VW-1:0] r_upper;
    } t_in_item;

    typedef struct packed {
        logic                 fail;
        logic signed [VW-1:0] new_x_lower;
        logic signed [VW-1:0] new_x_upper;
        logic signed [VW-1:0] new_q_lower;
        logic signed [VW-1:0] new_q_upper;
        logic signed [VW-1:0] new_r_lower;
        logic signed [VW-1:0] new_r_upper;
    } t_out_item;

    // Classified item passed from front to back; r is already clamped.
    typedef struct packed {
        logic                 fail;
        logic signed [VW-1:0] xl;
        logic signed [VW-1:0] xh;
        logic signed [VW-1:0] qlo;
        logic signed [VW-1:0] qhi;
        logic signed [VW-1:0] rlo;
        logic signed [VW-1:0] rhi;
    } t_work;

    // Partial state of the two divisions in flight.
    typedef struct packed {
        logic [VW-1:0] rem_lo;
        logic [VW-1:0] rem_hi;
        logic [VW-1:0] dq_lo;
        logic [VW-1:0] dq_hi;
    } t_div;

endpackage
`default_nettype wire

### rtl/core/dbp_front.sv
// Front part: input register that accepts items and flags early failures.
// Depends on dbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbp_front import dbp_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [CW-1:0] i_divisor,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire t_in_item      i_data,
    output logic               o_push,
    output t_work              o_work,
    input  wire logic          i_full
);

    logic  r_vld, n_vld;
    t_work r_work, n_work;
    logic  load;
    logic signed [VW-1:0] cm1;

    // Stall only when the held item cannot move into the queue.
    assign o_stall = r_vld & i_full;
    assign o_push  = r_vld & ~i_full;
    assign load    = i_valid & ~o_stall;
    assign o_work  = r_work;
    assign n_vld   = load | (r_vld & ~o_push);

    // Clamp r to [0, c-1] and flag divisor, r and x failures.
    always_comb begin
        cm1 = $signed({1'b0, i_divisor}) - 1;
        n_work.xl  = i_data.x_lower;
        n_work.xh  = i_data.x_upper;
        n_work.qlo = i_data.q_lower;
        n_work.qhi = i_data.q_upper;
        n_work.rlo = (i_data.r_lower < 0) ? '0 : i_data.r_lower;
        n_work.rhi = (i_data.r_upper < cm1) ? i_data.r_upper : cm1;
        n_work.fail = (i_divisor == '0) | (n_work.rlo > n_work.rhi) |
                      (i_data.x_lower < 0) | (i_data.x_upper < i_data.x_lower);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_work <= n_work;
        end
    end

endmodule
`default_nettype wire

### rtl/core/dbp_queue.sv
// Short queue that decouples the front from the back pipeline.
// Depends on dbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbp_queue import dbp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_work i_work,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_nonempty,
    output t_work      o_work
);

    t_work          mem [QD];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full     = (r_cnt == (QAW+1)'(QD));
    assign o_nonempty = (r_cnt != '0);
    assign o_work     = mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wp] <= i_work;
        end
    end

endmodule
`default_nettype wire

### rtl/core/dbp_back.sv
// Back part: pipelined restoring divider for both x bounds, then q, x and r narrowing.
// Depends on dbp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dbp_back import dbp_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [CW-1:0] i_divisor,
    input  wire logic          i_nonempty,
    input  wire t_work         i_work,
    output logic               o_pop,
    output logic               o_valid,
    output t_out_item          o_data,
    input  wire logic          i_stall
);

    logic          adv;
    logic [VW-1:0] cext;

    logic  r_dv [NSTG+1];
    t_work r_dw [NSTG+1];
    t_div  r_dd [NSTG+1];

    logic                 r_v1, r_v2, r_v3, r_ov;
    t_work                r_w1, r_w2, r_w3;
    logic [DW-1:0]        r_cqlo2, r_cqhi2, r_cqlo3, r_xlo3, r_xhi3;
    t_out_item            r_out, n_out;

    // The whole pipeline moves whenever the output register can take an item.
    assign adv     = ~r_ov | ~i_stall;
    assign o_pop   = adv & i_nonempty;
    assign cext    = {1'b0, i_divisor};
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // Stage 0 loads the dividends from the queue head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= i_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dw[0] <= i_work;
            r_dd[0] <= {{VW{1'b0}}, {VW{1'b0}}, i_work.xl, i_work.xh};
        end
    end

    // One quotient bit per stage for each bound.
    for (genvar k = 0; k < NSTG; k++) begin : g_div
        logic [VW-1:0] sh_lo, sh_hi, nr_lo, nr_hi;
        logic          ge_lo, ge_hi;
        always_comb begin
            sh_lo = {r_dd[k].rem_lo[VW-2:0], r_dd[k].dq_lo[VW-1]};
            sh_hi = {r_dd[k].rem_hi[VW-2:0], r_dd[k].dq_hi[VW-1]};
            ge_lo = (sh_lo >= cext);
            ge_hi = (sh_hi >= cext);
            nr_lo = ge_lo ? sh_lo - cext : sh_lo;
            nr_hi = ge_hi ? sh_hi - cext : sh_hi;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (adv) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dw[k+1] <= r_dw[k];
                r_dd[k+1] <= {nr_lo, nr_hi, {r_dd[k].dq_lo[VW-2:0], ge_lo},
                              {r_dd[k].dq_hi[VW-2:0], ge_hi}};
            end
        end
    end

    // Valid bits of the finishing stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= r_dv[NSTG];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    // Finishing stages: q bounds, products, x bounds, r residual.
    always_comb begin
        logic signed [DW-1:0] rmin, rmax, dlo, dhi;
        logic                 eq;
        eq   = (r_w3.qlo == r_w3.qhi);
        rmin = DW'(r_w3.rlo);
        rmax = DW'(r_w3.rhi);
        dlo  = $signed(r_xlo3 - r_cqlo3);
        dhi  = $signed(r_xhi3 - r_cqlo3);
        if (eq) begin
            if (dlo > rmin) begin
                rmin = dlo;
            end
            if (dhi < rmax) begin
                rmax = dhi;
            end
        end
        n_out.fail = r_w3.fail | (eq & (rmin > rmax));
        if (n_out.fail) begin
            n_out.new_x_lower = '0;
            n_out.new_x_upper = '0;
            n_out.new_q_lower = '0;
            n_out.new_q_upper = '0;
            n_out.new_r_lower = '0;
            n_out.new_r_upper = '0;
        end else begin
            n_out.new_x_lower = r_xlo3[VW-1:0];
            n_out.new_x_upper = r_xhi3[VW-1:0];
            n_out.new_q_lower = r_w3.qlo;
            n_out.new_q_upper = r_w3.qhi;
            n_out.new_r_lower = rmin[VW-1:0];
            n_out.new_r_upper = rmax[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [VW-1:0] qlo, qhi;
        logic [DW-1:0]        lsum, hsum, xl, xh, xlo, xhi;
        t_work                w1, w3;
        if (adv) begin
            // Tighten q with the quotients of the x bounds.
            qlo = $signed(r_dd[NSTG].dq_lo);
            qhi = $signed(r_dd[NSTG].dq_hi);
            w1  = r_dw[NSTG];
            if (qlo > w1.qlo) begin
                w1.qlo = qlo;
            end
            if (qhi < w1.qhi) begin
                w1.qhi = qhi;
            end
            w1.fail = w1.fail | (w1.qlo > w1.qhi);
            r_w1 <= w1;
            // Products c*q for both q bounds.
            r_w2    <= r_w1;
            r_cqlo2 <= DW'(i_divisor) * DW'(unsigned'(r_w1.qlo));
            r_cqhi2 <= DW'(i_divisor) * DW'(unsigned'(r_w1.qhi));
            // Tighten x with c*q + r.
            lsum = r_cqlo2 + DW'(unsigned'(r_w2.rlo));
            hsum = r_cqhi2 + DW'(unsigned'(r_w2.rhi));
            xl   = DW'(unsigned'(r_w2.xl));
            xh   = DW'(unsigned'(r_w2.xh));
            xlo  = (xl > lsum) ? xl : lsum;
            xhi  = (xh < hsum) ? xh : hsum;
            w3      = r_w2;
            w3.fail = r_w2.fail | (xlo > xhi);
            r_w3    <= w3;
            r_cqlo3 <= r_cqlo2;
            r_xlo3  <= xlo;
            r_xhi3  <= xhi;
            // Output register.
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

### rtl/core/divmod_bounds_propagator.sv
// Top level of the div/mod bounds propagator: APB divisor register, front, queue, back.
// Depends on dbp_pkg, dbp_front, dbp_queue and dbp_back.
//
//   channel   | direction | handshake                    | payload
//   in        | input     | i_in_valid / o_in_stall      | i_in_data  (t_in_item)
//   out       | output    | o_out_valid / i_out_stall    | o_out_data (t_out_item)
//   config    | input     | APB psel/penable/pwrite      | divisor at byte address 0
//
// One item per cycle is accepted while o_in_stall is low; each result then passes through
// the queue, divider load, 32 divider stages, 3 finishing stages and the output register.
// The latency is set by the one-bit-per-stage divider for the two x bounds.
// Reset is synchronous and active low; the divisor resets to 1.
// An output stall freezes the back pipeline; the queue lets the front keep accepting until it fills.
`timescale 1ns / 1ps
`default_nettype none
module divmod_bounds_propagator import dbp_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [AW-1:0] paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire t_in_item      i_in_data,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  wire logic          i_out_stall
);

    logic [CW-1:0] r_divisor;
    logic          push, full, pop, nonempty;
    t_work         fw, qw;

    // Divisor register on the APB port.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DIVISOR) ? {1'b0, r_divisor} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= DIVISOR_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_DIVISOR) begin
            r_divisor <= pwdata[CW-1:0];
        end
    end

    dbp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_divisor (r_divisor),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_data    (i_in_data),
        .o_push    (push),
        .o_work    (fw),
        .i_full    (full)
    );

    dbp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_work     (fw),
        .o_full     (full),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_work     (qw)
    );

    dbp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_divisor  (r_divisor),
        .i_nonempty (nonempty),
        .i_work     (qw),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .i_stall    (i_out_stall)
    );

endmodule
`default_nettype wire

### rtl/core/dbp_checker.sv
// Port-level checker for the div/mod bounds propagator, bound to the top level.
// Depends on dbp_pkg and divmod_bounds_propagator.
`timescale 1ns / 1ps
`default_nettype none
module dbp_checker import dbp_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data,
    input wire logic      pready
);

    // A failed item carries zero bounds (checked on x lower, q upper and both r bounds).
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.fail |->
            o_out_data.new_x_lower == '0 && o_out_data.new_q_upper == '0 &&
            o_out_data.new_r_lower == '0 && o_out_data.new_r_upper == '0)
        else $error("failed item with nonzero bounds");

    // A feasible item has ordered bounds and a nonnegative r lower bound.
    a_ok_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.fail |->
            o_out_data.new_x_lower <= o_out_data.new_x_upper &&
            o_out_data.new_q_lower <= o_out_data.new_q_upper &&
            o_out_data.new_r_lower >= 0 &&
            o_out_data.new_r_lower <= o_out_data.new_r_upper)
        else $error("feasible item with bad bounds");

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled item dropped or changed");

    // The APB port never inserts wait states.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind divmod_bounds_propagator dbp_checker u_dbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
`default_nettype wire

### dv/divmod_bounds_propagator_tb.sv
// Testbench for the div/mod bounds propagator: directed and random bound sets,
// divisor changes over APB, random idling on both channels. Depends on dbp_pkg.
`timescale 1ns / 1ps

module divmod_bounds_propagator_tb;
    import dbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 38;

    // Expected bounds are worked out when an item is accepted and checked in order.
    class bounds_scoreboard;
        t_out_item expected_q[$];
        logic [CW-1:0] divisor;
        int errors;
        int checked;

        function new();
            divisor = DIVISOR_RESET;
            errors = 0;
            checked = 0;
        endfunction

        // Narrows the bounds of x = c*q + r, 0 <= r < c, for one item.
        function t_out_item propagate(t_in_item it);
            t_out_item res;
            longint c, xl, xh, qmin, qmax, rmin, rmax, cqlo, lo, hi;
            c = longint'(divisor);
            xl = longint'(it.x_lower);
            xh = longint'(it.x_upper);
            res = '0;
            res.fail = 1'b1;
            if (c == 0) return res;
            rmin = (longint'(it.r_lower) > 0) ? longint'(it.r_lower) : 0;
            rmax = (longint'(it.r_upper) < c - 1) ? longint'(it.r_upper) : c - 1;
            if (rmin > rmax) return res;
            if (xl < 0 || xh < xl) return res;
            qmin = (longint'(it.q_lower) > xl / c) ? longint'(it.q_lower) : xl / c;
            qmax = (longint'(it.q_upper) < xh / c) ? longint'(it.q_upper) : xh / c;
            if (qmin > qmax) return res;
            cqlo = c * qmin;
            lo = (xl > cqlo + rmin) ? xl : cqlo + rmin;
            hi = (xh < c * qmax + rmax) ? xh : c * qmax + rmax;
            if (lo > hi) return res;
            if (qmin == qmax) begin
                if (lo - cqlo > rmin) rmin = lo - cqlo;
                if (hi - cqlo < rmax) rmax = hi - cqlo;
                if (rmin > rmax) return res;
            end
            res.fail = 1'b0;
            res.new_x_lower = lo[VW-1:0];
            res.new_x_upper = hi[VW-1:0];
            res.new_q_lower = qmin[VW-1:0];
            res.new_q_upper = qmax[VW-1:0];
            res.new_r_lower = rmin[VW-1:0];
            res.new_r_upper = rmax[VW-1:0];
            return res;
        endfunction

        function void note_item(t_in_item it);
            expected_q = {expected_q, propagate(it)};
        endfunction

        task check_result(t_out_item got);
            t_out_item exp_item;
            checked++;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", 0, 0);
                return;
            end
            exp_item = expected_q.pop_front();
            if (got.fail !== exp_item.fail)
                report_mismatch("fail", got.fail, exp_item.fail);
            if (got.new_x_lower !== exp_item.new_x_lower)
                report_mismatch("new_x_lower", got.new_x_lower, exp_item.new_x_lower);
            if (got.new_x_upper !== exp_item.new_x_upper)
                report_mismatch("new_x_upper", got.new_x_upper, exp_item.new_x_upper);
            if (got.new_q_lower !== exp_item.new_q_lower)
                report_mismatch("new_q_lower", got.new_q_lower, exp_item.new_q_lower);
            if (got.new_q_upper !== exp_item.new_q_upper)
                report_mismatch("new_q_upper", got.new_q_upper, exp_item.new_q_upper);
            if (got.new_r_lower !== exp_item.new_r_lower)
                report_mismatch("new_r_lower", got.new_r_lower, exp_item.new_r_lower);
            if (got.new_r_upper !== exp_item.new_r_upper)
                report_mismatch("new_r_upper", got.new_r_upper, exp_item.new_r_upper);
        endtask

        task report_mismatch(string field, longint got, longint want);
            errors++;
            $display("ERROR at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in_item i_in_data = '0;
    logic o_out_valid;
    t_out_item o_out_data;
    logic i_out_stall = 1'b0;

    bounds_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int idle_count = 0;
    int sent_count = 0;
    int fail_count = 0;

    always #10 i_clk = ~i_clk;

    divmod_bounds_propagator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall)
    );

    // Receiver: random stall, or a long hold-off counted here.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_out_data.fail) fail_count++;
            sb.check_result(o_out_data);
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog on cycles without any accepted item or delivered result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_count);
            $display("divmod_bounds_propagator: mismatch");
            $finish;
        end
    end

    // Writes the divisor over APB; block must be idle.
    task automatic write_divisor(logic [CW-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_DIVISOR;
        pwdata <= {1'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.divisor = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offers one item, holds it until accepted.
    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
        sent_count++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [VW-1:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(40);
            2: return 32'h7fffffff - $urandom_range(40);
            3: return 32'h80000000 + $urandom_range(40);
            default: return $urandom_range(5000);
        endcase
    endfunction

    // Mostly feasible sets built around a chosen x = c*q + r; the rest is noise.
    function automatic t_in_item make_item();
        t_in_item it;
        longint c, q, r, x, span;
        c = (sb.divisor == 0) ? 1 : longint'(sb.divisor);
        if ($urandom_range(3) == 0) begin
            it = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
        end else begin
            span = $urandom_range(3) == 0 ? longint'($urandom) : $urandom_range(200);
            x = $urandom_range(32'h7fffffff);
            if ($urandom_range(1)) x = x % (c * 8 + 1);
            q = x / c;
            r = x % c;
            it.x_lower = VW'((x - span < 0) ? 0 : x - span);
            it.x_upper = VW'((x + span > 32'h7fffffff) ? 32'h7fffffff : x + span);
            it.q_lower = VW'(q - longint'($urandom_range(3)));
            it.q_upper = VW'(q + longint'($urandom_range(3)));
            it.r_lower = VW'(r - longint'($urandom_range(32'(c > 100 ? 100 : c))));
            it.r_upper = VW'(r + longint'($urandom_range(32'(c > 100 ? 100 : c))));
            if ($urandom_range(9) == 0) it.q_upper = VW'(q);
            if ($urandom_range(9) == 0) it.q_lower = VW'(q);
        end
        return it;
    endfunction

    task automatic directed();
        logic [VW-1:0] mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        send_item({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        send_item({mx, mx, mn, mx, mn, mx});
        send_item({32'd0, mx, mn, mx, mn, mx});
        send_item({mn, mx, mn, mx, mn, mx});          // negative x lower bound
        send_item({32'd5, 32'd4, mn, mx, mn, mx});    // x interval empty
        send_item({32'd5, mn, mn, mx, mn, mx});       // negative x upper bound
        send_item({32'd0, 32'd100, 32'd5, 32'd3, mn, mx});  // q empty
        send_item({32'd0, 32'd100, mn, mx, 32'd9, 32'd2});  // r empty
        send_item({32'd0, 32'd100, mn, mx, mn, 32'hffffffff}); // r clamps empty
        send_item({32'd10, 32'd90, 32'd2, 32'd2, mn, mx});  // q fixed
        send_item({32'd0, mx, 32'd7, 32'd7, 32'd0, 32'd0});
        send_item({32'hffffffff, 32'hffffffff, 32'd1, 32'hffffffff, 32'd1, 32'd1});
    endtask

    task automatic random_phase(int n, int idle_pct, int st_pct);
        send_idle_pct = idle_pct;
        stall_pct = st_pct;
        repeat (n) send_item(make_item());
    endtask

    initial begin
        logic [CW-1:0] divisors[6];
        divisors = '{31'd1, 31'd0, 31'h7fffffff, 31'd7, 31'd1000, 31'd3};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset divisor first, then each setting in turn.
        foreach (divisors[i]) begin
            if (i != 0) write_divisor(divisors[i]);
            directed();
            random_phase(30, 0, 0);
            random_phase(30, 71, 0);
            random_phase(30, 0, 71);
            random_phase(30, 24, 24);
            drain();
        end
        // Random divisors with a long hold-off while the sender keeps offering.
        repeat (4) begin
            write_divisor(CW'($urandom_range(2) == 0 ? $urandom : $urandom_range(50)));
            hold_off = 200;
            random_phase(60, 0, 0);
            drain();
        end

        $display("Sent %0d items over 10 divisor settings, %0d results checked, %0d infeasible.",
                 sent_count, sb.checked, fail_count);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("divmod_bounds_propagator: match");
        else
            $display("divmod_bounds_propagator: mismatch");
        $finish;
    end
endmodule

### divmod_bounds_propagator.f
rtl/core/dbp_pkg.sv
rtl/core/dbp_front.sv
rtl/core/dbp_queue.sv
rtl/core/dbp_back.sv
rtl/core/divmod_bounds_propagator.sv
rtl/core/dbp_checker.sv
dv/divmod_bounds_propagator_tb.sv
